### hdl/dlt_pkg.sv
// Shared types, constants and helpers for the delta-list timer queue.
// No dependencies; used by dlt_cell, dlt_ctrl and delta_list_timer_queue_top.
`timescale 1ns / 1ps

package dlt_pkg;

    localparam int SLOTS       = 16;  // timer cells in the chain
    localparam int DELAY_BITS  = 16;  // width of a stored delta
    localparam int DELAY_IN_W  = 16;  // width of the delay port
    localparam int OWNER_BITS  = 4;

    localparam logic [32:0] DELTA_MAX = (33'd1 << DELAY_BITS) - 33'd1;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    typedef enum logic {
        TOK_SEARCH = 1'b0,  // still looking for the sorted position
        TOK_CARRY  = 1'b1   // pushing a displaced entry toward the tail
    } tok_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_POP
    } state_t;

    // One timer entry held by a cell.
    typedef struct packed {
        logic                  valid;
        logic [DELAY_BITS-1:0] delta;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    // Insert token handed from cell to cell.
    typedef struct packed {
        logic                  valid;
        tok_mode_t             mode;
        logic [DELAY_BITS-1:0] delta;
        logic [OWNER_BITS-1:0] owner;
    } tok_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic dec;  // decrement the held delta, saturating at zero
        logic shl;  // take the right neighbor's entry (pop the head)
    } cell_ctl_t;

    // Chain status seen by the sequencer.
    typedef struct packed {
        entry_t head;
        entry_t second;
        logic   full;
        logic   busy;   // a token is somewhere in the chain
    } chain_status_t;

    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [DELAY_IN_W-1:0] d);
        logic [32:0] wide;
        wide = 33'(d);
        if (wide > DELTA_MAX) begin
            return DELTA_MAX[DELAY_BITS-1:0];
        end
        return wide[DELAY_BITS-1:0];
    endfunction

endpackage

### hdl/dlt_cell.sv
// One cell of the sorted timer chain: holds one entry and one token stage.
// Depends on dlt_pkg.
`timescale 1ns / 1ps

module dlt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  dlt_pkg::cell_ctl_t ctl,
    input  dlt_pkg::tok_t      tok_in,
    input  dlt_pkg::entry_t    right_in,
    output dlt_pkg::tok_t      tok_out,
    output dlt_pkg::entry_t    ent_out
);

    dlt_pkg::entry_t ent_reg, ent_next;
    dlt_pkg::tok_t   tok_reg, tok_next;

    always_comb begin
        ent_next = ent_reg;
        tok_next = '0;
        if (ctl.shl) begin
            ent_next = right_in;
        end else if (ctl.dec) begin
            if (ent_reg.valid && (ent_reg.delta != '0)) begin
                ent_next.delta = ent_reg.delta - {{(dlt_pkg::DELAY_BITS-1){1'b0}}, 1'b1};
            end
        end else if (tok_in.valid) begin
            case (tok_in.mode)
                dlt_pkg::TOK_SEARCH: begin
                    if (!ent_reg.valid) begin
                        ent_next = '{valid: 1'b1, delta: tok_in.delta, owner: tok_in.owner};
                    end else if (tok_in.delta >= ent_reg.delta) begin
                        // pass on with the remaining delay
                        tok_next = '{valid: 1'b1, mode: dlt_pkg::TOK_SEARCH,
                                     delta: tok_in.delta - ent_reg.delta,
                                     owner: tok_in.owner};
                    end else begin
                        // take the new entry, push the old one with its reduced delta
                        ent_next = '{valid: 1'b1, delta: tok_in.delta, owner: tok_in.owner};
                        tok_next = '{valid: 1'b1, mode: dlt_pkg::TOK_CARRY,
                                     delta: ent_reg.delta - tok_in.delta,
                                     owner: ent_reg.owner};
                    end
                end
                dlt_pkg::TOK_CARRY: begin
                    ent_next = '{valid: 1'b1, delta: tok_in.delta, owner: tok_in.owner};
                    if (ent_reg.valid) begin
                        tok_next = '{valid: 1'b1, mode: dlt_pkg::TOK_CARRY,
                                     delta: ent_reg.delta, owner: ent_reg.owner};
                    end
                end
                default: begin
                    tok_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            ent_reg <= ent_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign ent_out = ent_reg;

endmodule

### hdl/dlt_ctrl.sv
// Sequencer of the timer queue: input handshake, insert launch, tick pops
// and the result register. Depends on dlt_pkg.
`timescale 1ns / 1ps

module dlt_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [dlt_pkg::OWNER_BITS-1:0] s_owner_id,
    input  logic [dlt_pkg::DELAY_IN_W-1:0] s_delay,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [dlt_pkg::OWNER_BITS-1:0] m_owner_out,
    output logic                           m_last,
    input  dlt_pkg::chain_status_t         status,
    output dlt_pkg::cell_ctl_t             ctl,
    output dlt_pkg::tok_t                  inj
);

    dlt_pkg::state_t state_reg, state_next;
    dlt_pkg::tok_t   inj_reg, inj_next;

    logic                           m_valid_reg;
    dlt_pkg::kind_t                 m_kind_reg, kind_next;
    logic [dlt_pkg::OWNER_BITS-1:0] m_owner_reg, owner_next;
    logic                           m_last_reg, last_next;
    logic                           load;
    logic                           out_free;
    logic                           busy;
    logic                           pop_last;

    assign out_free = !m_valid_reg || m_ready;
    assign busy     = status.busy || inj_reg.valid;
    assign pop_last = !(status.second.valid && (status.second.delta == '0));

    always_comb begin
        state_next = state_reg;
        inj_next   = '0;
        ctl        = '0;
        s_ready    = 1'b0;
        load       = 1'b0;
        kind_next  = dlt_pkg::KIND_ACCEPTED;
        owner_next = s_owner_id;
        last_next  = 1'b1;
        case (state_reg)
            dlt_pkg::ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (s_cmd == dlt_pkg::CMD_INSERT) begin
                        load = 1'b1;
                        if (status.full) begin
                            kind_next = dlt_pkg::KIND_FULL;
                        end else begin
                            inj_next   = '{valid: 1'b1, mode: dlt_pkg::TOK_SEARCH,
                                           delta: dlt_pkg::sat_delay(s_delay),
                                           owner: s_owner_id};
                            state_next = dlt_pkg::ST_INSERT;
                        end
                    end else if (status.head.valid) begin
                        ctl.dec    = 1'b1;
                        state_next = dlt_pkg::ST_POP;
                    end
                end
            end
            dlt_pkg::ST_INSERT: begin
                if (!busy) begin
                    state_next = dlt_pkg::ST_IDLE;
                end
            end
            dlt_pkg::ST_POP: begin
                if (status.head.valid && (status.head.delta == '0)) begin
                    if (out_free) begin
                        load       = 1'b1;
                        kind_next  = dlt_pkg::KIND_EXPIRED;
                        owner_next = status.head.owner;
                        last_next  = pop_last;
                        ctl.shl    = 1'b1;
                        if (pop_last) begin
                            state_next = dlt_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    state_next = dlt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dlt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dlt_pkg::ST_IDLE;
            inj_reg.valid <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            inj_reg   <= inj_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_kind_reg  <= kind_next;
            m_owner_reg <= owner_next;
            m_last_reg  <= last_next;
        end
    end

    assign inj         = inj_reg;
    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_owner_out = m_owner_reg;
    assign m_last      = m_last_reg;

    a_no_shift_with_token: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.shl && (busy || ctl.dec)))
        else $error("pop overlaps an insert or decrement");

    a_pop_only_due: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shl |-> (status.head.valid && (status.head.delta == '0)))
        else $error("popped a head that is not due");

    a_insert_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == dlt_pkg::CMD_INSERT) && !status.full)
        |=> (inj_reg.valid && (state_reg == dlt_pkg::ST_INSERT)))
        else $error("insert token not launched");

    a_idle_chain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dlt_pkg::ST_IDLE) |-> !busy)
        else $error("token in flight while idle");

endmodule

### hdl/delta_list_timer_queue_top.sv
// Top level of the delta-list timer queue: sequencer plus a chain of cells.
// Depends on dlt_pkg, dlt_cell and dlt_ctrl.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+----------------
//   s_      | in        | s_cmd, s_owner_id, s_delay              | s_valid/s_ready
//   m_      | out       | m_kind, m_owner_out, m_last             | m_valid/m_ready
//
// Insert: the transaction is accepted, then a token walks the chain one cell
//   per cycle until it is placed, and the next transaction is taken once it
//   is done; an insert rejected on a full queue launches no token.
// Tick: the head is decremented, then expired timers pop one per cycle while
//   m_ready allows, or the tick ends with nothing due; an empty queue pops nothing.
// Reset (aresetn low, synchronous) clears the cell valid bits: the queue
//   comes up empty with no clearing pass.
// m_ready low holds the result register and stalls further pops.
`timescale 1ns / 1ps

module delta_list_timer_queue_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [dlt_pkg::OWNER_BITS-1:0] s_owner_id,
    input  logic [dlt_pkg::DELAY_IN_W-1:0] s_delay,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [dlt_pkg::OWNER_BITS-1:0] m_owner_out,
    output logic                           m_last
);

    // The chain is the sorted list itself: cell 0 holds the head, each cell
    // holds its delay relative to the cell on its left, valid cells are
    // always packed from cell 0 upward.
    dlt_pkg::entry_t    ent_arr   [dlt_pkg::SLOTS];
    dlt_pkg::entry_t    right_arr [dlt_pkg::SLOTS];
    dlt_pkg::tok_t      tok_arr   [dlt_pkg::SLOTS];
    dlt_pkg::tok_t      tok_in_arr[dlt_pkg::SLOTS];
    dlt_pkg::cell_ctl_t cell_ctl  [dlt_pkg::SLOTS];
    logic [dlt_pkg::SLOTS-1:0] busy_vec;

    dlt_pkg::cell_ctl_t     ctl;
    dlt_pkg::tok_t          inj;
    dlt_pkg::chain_status_t status;

    dlt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_owner_id  (s_owner_id),
        .s_delay     (s_delay),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_owner_out (m_owner_out),
        .m_last      (m_last),
        .status      (status),
        .ctl         (ctl),
        .inj         (inj)
    );

    for (genvar i = 0; i < dlt_pkg::SLOTS; i++) begin : g_cell
        // Feed the token from the left neighbor, or from the sequencer at the head.
        if (i == 0) begin : g_head
            assign tok_in_arr[i] = inj;
        end else begin : g_body
            assign tok_in_arr[i] = tok_arr[i-1];
        end

        // Shift in from the right on a pop; the tail shifts in an empty entry.
        if (i == dlt_pkg::SLOTS - 1) begin : g_tail
            assign right_arr[i] = '0;
        end else begin : g_inner
            assign right_arr[i] = ent_arr[i+1];
        end

        // Only the head takes the tick decrement.
        assign cell_ctl[i] = {(i == 0) && ctl.dec, ctl.shl};
        assign busy_vec[i] = tok_arr[i].valid;

        dlt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl[i]),
            .tok_in   (tok_in_arr[i]),
            .right_in (right_arr[i]),
            .tok_out  (tok_arr[i]),
            .ent_out  (ent_arr[i])
        );
    end

    assign status.head   = ent_arr[0];
    assign status.second = ent_arr[1];
    assign status.full   = ent_arr[dlt_pkg::SLOTS-1].valid;
    assign status.busy   = |busy_vec;

endmodule
